// ----- src/sdf_pkg.sv -----
`default_nettype none

package sdf_pkg;

    localparam int unsigned MAX_DISTINCT = 256;
    localparam int unsigned KEY_BYTES    = 4;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned ADDR_W  = $clog2(MAX_DISTINCT);
    localparam int unsigned IDX_W   = $clog2(MAX_DISTINCT + 1);

    localparam int unsigned OUT_DATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;
    localparam int unsigned OUT_PAD_W  = OUT_DATA_W - VALUE_W - COUNT_W;
    localparam int unsigned OUT_USER_W = 2;

    localparam logic [VALUE_W-1:0] KEY_MASK = (KEY_BYTES >= 4) ? {VALUE_W{1'b1}} :
        VALUE_W'((64'd1 << (8 * KEY_BYTES)) - 64'd1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- src/stream_duplicate_filter_top.sv -----
// Order-preserving duplicate filter for a key stream.
// Input channel: one key per item, tlast on the last key of an array.
// Output channel: exactly one result item per input item, in order.
//   tdata carries the echoed key and the running distinct count,
//   tuser flags a first occurrence (new) or a new key that found the table full.
// Distinct keys of the current array sit in a 256 x 32 single-port-read memory
// with a registered read port; each key is searched by reading one entry a cycle.
// Reads run in order from entry zero; each read is compared with the key, and a
// match ends the search early. Once the last stored entry has been compared,
// the result is registered in the output register and a fresh key is stored,
// then the block returns to idle for the next item. The search length grows with
// the count, up to MAX_DISTINCT reads, set by the single read port.
// One item is searched at a time; the next is accepted as soon as the result
// has moved into the output register, even if the receiver has not taken it.
// If the receiver stalls with a result still held, the next result waits in
// the search engine and the input stalls behind it.
// Reset empties the table (count to zero) and drops any held result; memory
// contents need no clearing as only entries below the count are read.
// The count clears after the result of a tlast item.
`default_nettype none

module stream_duplicate_filter_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [sdf_pkg::VALUE_W-1:0]         i_s_tdata,  // value
    input  wire logic                                i_s_tlast,  // last
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic [sdf_pkg::OUT_DATA_W-1:0]           o_m_tdata,  // key_out, distinct_count, pad
    output logic [sdf_pkg::OUT_USER_W-1:0]           o_m_tuser,  // is_new, overflow
    output logic                                     o_m_tlast   // is_final
);

    logic [sdf_pkg::VALUE_W-1:0] r_mem [sdf_pkg::MAX_DISTINCT];
    logic [sdf_pkg::VALUE_W-1:0] r_rd_data;

    sdf_pkg::t_state r_state, n_state;

    logic [sdf_pkg::VALUE_W-1:0]    r_value, n_value;
    logic                           r_last, n_last;
    logic [sdf_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic [sdf_pkg::IDX_W-1:0]      r_count, n_count;
    logic                           r_cmp_valid, n_cmp_valid;
    logic                           r_found, n_found;

    logic                           r_out_valid, n_out_valid;
    logic [sdf_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic [sdf_pkg::OUT_USER_W-1:0] r_out_user, n_out_user;
    logic                           r_out_last, n_out_last;

    logic                           w_rd_en;
    logic                           w_wr_en;
    logic [sdf_pkg::VALUE_W-1:0]    w_key;
    logic                           w_hit;
    logic                           w_fresh;
    logic                           w_full;
    logic [sdf_pkg::IDX_W-1:0]      w_new_count;

    assign w_key  = r_value & sdf_pkg::KEY_MASK;
    assign w_hit  = r_cmp_valid && (r_rd_data == w_key);
    assign w_full = (r_count == sdf_pkg::IDX_W'(sdf_pkg::MAX_DISTINCT));
    assign w_fresh = !r_found && !w_full;
    assign w_new_count = r_count + sdf_pkg::IDX_W'(w_fresh);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[sdf_pkg::ADDR_W-1:0]] <= w_key;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_idx[sdf_pkg::ADDR_W-1:0]];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_value     = r_value;
        n_last      = r_last;
        n_idx       = r_idx;
        n_count     = r_count;
        n_cmp_valid = 1'b0;
        n_found     = r_found;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_out_last  = r_out_last;
        o_s_tready  = 1'b0;
        w_rd_en     = 1'b0;
        w_wr_en     = 1'b0;
        case (r_state)
            sdf_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_value = i_s_tdata;
                    n_last  = i_s_tlast;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = sdf_pkg::S_SEARCH;
                end
            end
            sdf_pkg::S_SEARCH: begin
                if (w_hit) begin
                    n_found = 1'b1;
                    n_state = sdf_pkg::S_DONE;
                end else if (r_idx == r_count) begin
                    n_found = 1'b0;
                    n_state = sdf_pkg::S_DONE;
                end else begin
                    w_rd_en     = 1'b1;
                    n_idx       = r_idx + sdf_pkg::IDX_W'(1);
                    n_cmp_valid = 1'b1;
                end
            end
            sdf_pkg::S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    w_wr_en     = w_fresh;
                    n_out_valid = 1'b1;
                    n_out_data  = {{sdf_pkg::OUT_PAD_W{1'b0}},
                                   sdf_pkg::COUNT_W'(w_new_count), r_value};
                    n_out_user  = {!r_found && w_full, w_fresh};
                    n_out_last  = r_last;
                    n_count     = r_last ? '0 : w_new_count;
                    n_state     = sdf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sdf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sdf_pkg::S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_cmp_valid <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_cmp_valid <= n_cmp_valid;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value    <= n_value;
        r_last     <= n_last;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sdf_pkg::IDX_W'(sdf_pkg::MAX_DISTINCT))
        else $error("table count above capacity");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_user[0] && r_out_user[1]))
        else $error("new and overflow both set");

    a_accept_starts_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == sdf_pkg::S_SEARCH))
        else $error("accepted item did not start a search");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sdf_pkg::S_DONE && (!r_out_valid || i_m_tready) && r_last)
        |=> (r_count == '0))
        else $error("count not cleared after last item");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |-> (r_idx < r_count))
        else $error("read beyond stored keys");

endmodule

`default_nettype wire

// ----- test/sdf_result_checker.sv -----
`timescale 1ns / 100ps

module sdf_result_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    input  wire logic                           i_s_tready,
    input  wire logic [sdf_pkg::VALUE_W-1:0]    i_s_tdata,   // value
    input  wire logic                           i_s_tlast,   // last
    input  wire logic                           i_m_tvalid,
    input  wire logic                           i_m_tready,
    input  wire logic [sdf_pkg::OUT_DATA_W-1:0] i_m_tdata,   // key_out, distinct_count, pad
    input  wire logic [sdf_pkg::OUT_USER_W-1:0] i_m_tuser,   // is_new, overflow
    input  wire logic                           i_m_tlast,   // is_final
    output int                                  o_fail_count,
    output int                                  o_outstanding
);

    localparam int USER_NEW = 0;
    localparam int USER_OVF = 1;

    typedef struct packed {
        logic [sdf_pkg::VALUE_W-1:0] key;
        logic [sdf_pkg::COUNT_W-1:0] count;
        logic                        is_new;
        logic                        is_final;
        logic                        overflow;
    } t_dedup_result;

    logic [sdf_pkg::VALUE_W-1:0]   stored_keys [sdf_pkg::MAX_DISTINCT];
    int                            stored_n;
    t_dedup_result                 awaited_results [$];
    t_dedup_result                 want;
    t_dedup_result                 got;
    logic [sdf_pkg::OUT_PAD_W-1:0] pad;
    int                            n_fail;

    initial begin
        stored_n      = 0;
        n_fail        = 0;
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    function automatic t_dedup_result dedup_lookup(logic [sdf_pkg::VALUE_W-1:0] value,
                                                   logic fin);
        t_dedup_result               r;
        logic [sdf_pkg::VALUE_W-1:0] k;
        bit                          hit;
        k   = value & sdf_pkg::KEY_MASK;
        hit = 1'b0;
        for (int i = 0; i < stored_n; i++) begin
            if (stored_keys[i] == k) begin
                hit = 1'b1;
            end
        end
        r.key      = value;
        r.is_new   = 1'b0;
        r.overflow = 1'b0;
        if (!hit) begin
            if (stored_n < sdf_pkg::MAX_DISTINCT) begin
                stored_keys[stored_n] = k;
                stored_n++;
                r.is_new = 1'b1;
            end else begin
                r.overflow = 1'b1;
            end
        end
        r.count    = stored_n[sdf_pkg::COUNT_W-1:0];
        r.is_final = fin;
        if (fin) begin
            stored_n = 0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stored_n = 0;
            awaited_results.delete();
            o_outstanding <= 0;
        end else begin
            // older results leave before this edge's item is predicted
            if (i_m_tvalid && i_m_tready) begin
                got.key      = i_m_tdata[sdf_pkg::VALUE_W-1:0];
                got.count    = i_m_tdata[sdf_pkg::VALUE_W +: sdf_pkg::COUNT_W];
                got.is_new   = i_m_tuser[USER_NEW];
                got.overflow = i_m_tuser[USER_OVF];
                got.is_final = i_m_tlast;
                pad          = i_m_tdata[sdf_pkg::OUT_DATA_W-1 -: sdf_pkg::OUT_PAD_W];
                if (awaited_results.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 100) begin
                        $display("%0t: unexpected item: key %h count %0d new %b",
                                 $time, got.key, got.count, got.is_new,
                                 " final %b ovf %b", got.is_final, got.overflow);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    if (got !== want || pad !== '0) begin
                        n_fail++;
                        if (n_fail <= 100) begin
                            $display("%0t: mismatch: expected key %h count %0d new %b",
                                     $time, want.key, want.count, want.is_new,
                                     " final %b ovf %b pad 0",
                                     want.is_final, want.overflow);
                            $display("%0t:           actual key %h count %0d new %b",
                                     $time, got.key, got.count, got.is_new,
                                     " final %b ovf %b pad %h",
                                     got.is_final, got.overflow, pad);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                awaited_results.push_back(dedup_lookup(i_s_tdata, i_s_tlast));
            end
            o_outstanding <= awaited_results.size();
        end
        o_fail_count <= n_fail;
    end

endmodule

// ----- test/tb_stream_duplicate_filter_top.sv -----
`timescale 1ns / 100ps

module tb_stream_duplicate_filter_top;

    localparam int RANDOM_ITEMS = 420;
    localparam int BIG_START    = 100;
    localparam int HOLD_CYCLES  = 600;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [sdf_pkg::VALUE_W-1:0]    s_tdata  = '0;   // value
    logic                           s_tlast  = 1'b0; // last
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [sdf_pkg::OUT_DATA_W-1:0] m_tdata;         // key_out, distinct_count, pad
    logic [sdf_pkg::OUT_USER_W-1:0] m_tuser;         // is_new, overflow
    logic                           m_tlast;         // is_final

    int fail_count;
    int outstanding;
    bit quiet     = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;

    stream_duplicate_filter_top u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    sdf_result_checker u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tlast     (s_tlast),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_m_tlast     (m_tlast),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_key(input logic [sdf_pkg::VALUE_W-1:0] value, input logic fin);
        if (!quiet) begin
            while ($urandom_range(0, 99) < 30) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // receiver: random back-pressure, one long hold-off to fill the block
    initial begin
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            m_tready <= quiet || ($urandom_range(0, 99) >= 30);
        end
    end

    initial begin
        logic [sdf_pkg::VALUE_W-1:0] base;
        logic [sdf_pkg::VALUE_W-1:0] value;
        logic [sdf_pkg::VALUE_W-1:0] array_keys [$];
        int                          n_random;
        int                          len;
        int                          pick;
        bit                          big;
        bit                          big_done;

        n_random = 0;
        big_done = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // repeats, field extremes, clearing after last
        send_key(32'h0000_0000, 1'b0);
        send_key(32'h0000_0000, 1'b0);
        send_key(32'hFFFF_FFFF, 1'b0);
        send_key(32'h8000_0000, 1'b0);
        send_key(32'h0000_0001, 1'b0);
        send_key(32'hFFFF_FFFF, 1'b0);
        send_key(32'h7FFF_FFFF, 1'b0);
        send_key(32'h0000_0000, 1'b1);
        send_key(32'hFFFF_FFFF, 1'b1);
        send_key(32'h0000_0000, 1'b0);
        send_key(32'h0000_0000, 1'b1);
        send_key(32'h5555_5555, 1'b0);
        send_key(32'hAAAA_AAAA, 1'b0);
        send_key(32'h5555_5555, 1'b1);

        // table full: 256 distinct keys, then overflowing and repeated ones
        base = $urandom;
        for (int i = 0; i < sdf_pkg::MAX_DISTINCT; i++) begin
            send_key(base + i * 32'h9E37_79B1, 1'b0);
        end
        send_key(base + sdf_pkg::MAX_DISTINCT * 32'h9E37_79B1, 1'b0);
        send_key(base, 1'b0);
        send_key(base + (sdf_pkg::MAX_DISTINCT + 1) * 32'h9E37_79B1, 1'b0);
        send_key(base + sdf_pkg::MAX_DISTINCT * 32'h9E37_79B1, 1'b1);
        send_key(base, 1'b1);

        while (n_random < RANDOM_ITEMS) begin
            big = !big_done && n_random >= BIG_START;
            if (big) begin
                big_done = 1'b1;
                len = $urandom_range(258, 275);
            end else begin
                len = $urandom_range(1, 24);
            end
            array_keys.delete();
            for (int j = 0; j < len; j++) begin
                pick = $urandom_range(0, 99);
                if (array_keys.size() > 0 && pick < (big ? 8 : 35)) begin
                    value = array_keys[$urandom_range(0, array_keys.size() - 1)];
                end else if (!big && pick < 55) begin
                    case ($urandom_range(0, 3))
                        0: value = '0;
                        1: value = '1;
                        2: value = 32'h1 << $urandom_range(0, 31);
                        default: value = $urandom_range(0, 15);
                    endcase
                end else begin
                    value = $urandom;
                end
                array_keys.push_back(value);
                send_key(value, j == len - 1);
                n_random++;
                quiet    = (n_random >= 120 && n_random < 220);
                hold_req = (n_random >= 60);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (300) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
